FILE: rtl/u8d_pkg.sv
// Shared types, constants and value checks for the UTF-8 decoder.
package u8d_pkg;

  localparam int unsigned CpWidth = 31;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_STRAY    = 3'd1,
    ST_BADLEAD  = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_OVERLONG = 3'd4,
    ST_SURR     = 3'd5,
    ST_NONCHAR  = 3'd6
  } status_e;

  localparam logic [CpWidth-1:0] Replacement = 31'h0000_FFFD;
  localparam logic [CpWidth-1:0] SurrLow     = 31'h0000_D800;
  localparam logic [CpWidth-1:0] SurrHigh    = 31'h0000_DFFF;
  localparam logic [15:0]        NonCharMask = 16'hFFFE;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    status_e            status;
  } result_t;

  // One queue entry holds every result caused by a single input word.
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  function automatic logic [CpWidth-1:0] min_for_len(input logic [2:0] len);
    logic [CpWidth-1:0] m;
    case (len)
      3'd2:    m = 31'h0000_0080;
      3'd3:    m = 31'h0000_0800;
      3'd4:    m = 31'h0001_0000;
      3'd5:    m = 31'h0020_0000;
      3'd6:    m = 31'h0400_0000;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic status_e check_value(input logic [CpWidth-1:0] c,
                                          input logic [2:0] len);
    status_e st;
    if (c < min_for_len(len)) begin
      st = ST_OVERLONG;
    end else if (c >= SurrLow && c <= SurrHigh) begin
      st = ST_SURR;
    end else if ((c[15:0] & NonCharMask) == NonCharMask) begin
      st = ST_NONCHAR;
    end else begin
      st = ST_OK;
    end
    return st;
  endfunction

endpackage

FILE: rtl/u8d_if.sv
// Valid/ready channel interfaces for input bytes and decoded results.
interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface u8d_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] code_point;
  logic [2:0]  status;
  logic        last_of_run;

  modport source (output valid, output code_point, output status, output last_of_run,
                  input ready);
  modport sink (input valid, input code_point, input status, input last_of_run,
                output ready);
endinterface

FILE: rtl/u8d_front.sv
// Front end: accepts bytes, tracks the open sequence and forms result entries.
module u8d_front
  import u8d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  input  logic       full_i,
  output logic       ready_o,
  output logic       push_o,
  output entry_t     entry_o
);

  logic [2:0]         pend_q, pend_d;
  logic [2:0]         len_q, len_d;
  logic [CpWidth-1:0] acc_q, acc_d;
  logic [1:0]         cnt;
  result_t            res [2];
  logic               fresh;
  logic [CpWidth-1:0] acc_sh;
  logic [2:0]         pend_m;
  logic [2:0]         n;
  status_e            st;
  logic               accept;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    pend_d = pend_q;
    len_d  = len_q;
    acc_d  = acc_q;
    cnt    = 2'd0;
    res[0] = '{code_point: Replacement, status: ST_TRUNC};
    res[1] = '{code_point: Replacement, status: ST_TRUNC};
    fresh  = 1'b1;
    acc_sh = {acc_q[CpWidth-7:0], in_byte_i[5:0]};
    pend_m = pend_q - 3'd1;
    n      = 3'd2;
    st     = check_value(acc_sh, len_q);

    if (pend_q != 3'd0) begin
      if (in_byte_i[7:6] == 2'b10) begin
        fresh  = 1'b0;
        acc_d  = acc_sh;
        pend_d = pend_m;
        if (pend_m == 3'd0) begin
          res[cnt[0]] = '{code_point: (st == ST_OK) ? acc_sh : Replacement, status: st};
          cnt    = cnt + 2'd1;
          acc_d  = '0;
          len_d  = 3'd0;
        end
      end else begin
        res[cnt[0]] = '{code_point: Replacement, status: ST_TRUNC};
        cnt    = cnt + 2'd1;
        pend_d = 3'd0;
        acc_d  = '0;
        len_d  = 3'd0;
      end
    end

    if (fresh) begin
      if (!in_byte_i[7]) begin
        res[cnt[0]] = '{code_point: {{(CpWidth-8){1'b0}}, in_byte_i}, status: ST_OK};
        cnt = cnt + 2'd1;
      end else if (in_byte_i[7:6] == 2'b10) begin
        res[cnt[0]] = '{code_point: Replacement, status: ST_STRAY};
        cnt = cnt + 2'd1;
      end else if (in_byte_i[7:1] == 7'h7F) begin
        res[cnt[0]] = '{code_point: Replacement, status: ST_BADLEAD};
        cnt = cnt + 2'd1;
      end else begin
        if (in_byte_i[7:2] == 6'h3F) begin
          n = 3'd6;
        end else if (in_byte_i[7:3] == 5'h1F) begin
          n = 3'd5;
        end else if (in_byte_i[7:4] == 4'hF) begin
          n = 3'd4;
        end else if (in_byte_i[7:5] == 3'h7) begin
          n = 3'd3;
        end
        len_d  = n;
        pend_d = n - 3'd1;
        acc_d  = {{(CpWidth-8){1'b0}}, in_byte_i & (8'h7F >> n)};
      end
    end

    if (end_of_input_i && pend_d != 3'd0) begin
      res[cnt[0]] = '{code_point: Replacement, status: ST_TRUNC};
      cnt    = cnt + 2'd1;
      pend_d = 3'd0;
      acc_d  = '0;
      len_d  = 3'd0;
    end
  end

  assign push_o        = accept && (cnt != 2'd0);
  assign entry_o.two   = cnt[1];
  assign entry_o.r0    = res[0];
  assign entry_o.r1    = res[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 3'd0;
      len_q  <= 3'd0;
      acc_q  <= '0;
    end else if (accept) begin
      pend_q <= pend_d;
      len_q  <= len_d;
      acc_q  <= acc_d;
    end
  end

`ifndef SYNTHESIS
  // An open sequence always expects fewer continuation words than its length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 3'd0 |-> (len_q > pend_q) && (len_q >= 3'd2) && (len_q <= 3'd6))
    else $error("pending count does not fit the sequence length");
  // A word marked as the last one leaves no sequence open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_of_input_i |=> pend_q == 3'd0)
    else $error("sequence left open after end of input");
`endif

endmodule

FILE: rtl/u8d_fifo.sv
// Short queue of result entries between the front and the back end.
module u8d_fifo
  import u8d_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  input  logic   pop_i,
  output entry_t pop_data_o,
  output logic   empty_o,
  output logic   full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign empty_o    = (cnt_q == '0);
  assign full_o     = (cnt_q == FullCnt);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  // The front end must never offer an entry to a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i)
    else $error("push into a full queue");
`endif

endmodule

FILE: rtl/u8d_back.sv
// Back end: holds one entry and hands out its results one word at a time.
module u8d_back
  import u8d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  entry_t      entry_i,
  output logic        pop_o,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [30:0] code_point_o,
  output logic [2:0]  status_o,
  output logic        last_of_run_o
);

  entry_t  cur_q;
  logic    cur_vld_q;
  logic    sel_q;
  logic    last;
  logic    done;
  result_t res;

  assign last          = sel_q || !cur_q.two;
  assign done          = valid_o && ready_i;
  assign pop_o         = !empty_i && (!cur_vld_q || (done && last));
  assign res           = sel_q ? cur_q.r1 : cur_q.r0;
  assign valid_o       = cur_vld_q;
  assign code_point_o  = res.code_point;
  assign status_o      = res.status;
  assign last_of_run_o = last;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      sel_q     <= 1'b0;
    end else if (pop_o) begin
      cur_vld_q <= 1'b1;
      sel_q     <= 1'b0;
    end else if (done) begin
      if (last) begin
        cur_vld_q <= 1'b0;
        sel_q     <= 1'b0;
      end else begin
        sel_q <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // The second result is only ever selected in a held entry that has one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> cur_vld_q && cur_q.two)
    else $error("second result selected without one");
`endif

endmodule

FILE: rtl/utf8_to_code_point_decoder.sv
// Top level of the UTF-8 to code point decoder.
// A result word is registered in the entry queue and then in the back-end holding register.
// Throughput: one byte per cycle while the entry queue is not full; a byte causing two
// results is handed out as two words. The input stalls only when the entry queue is full.
// Reset is asynchronous and active low; it closes any open sequence and empties the queue.
module utf8_to_code_point_decoder
  import u8d_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  u8d_in_if.sink    in_i,
  u8d_out_if.source out_o
);

  logic   full, empty, push, pop;
  entry_t push_entry, pop_entry;

  u8d_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (in_i.valid),
    .in_byte_i      (in_i.in_byte),
    .end_of_input_i (in_i.end_of_input),
    .full_i         (full),
    .ready_o        (in_i.ready),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  u8d_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .pop_data_o  (pop_entry),
    .empty_o     (empty),
    .full_o      (full)
  );

  u8d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .entry_i       (pop_entry),
    .pop_o         (pop),
    .valid_o       (out_o.valid),
    .ready_i       (out_o.ready),
    .code_point_o  (out_o.code_point),
    .status_o      (out_o.status),
    .last_of_run_o (out_o.last_of_run)
  );

endmodule
